// File: rtl/assert_macros.svh
// Assertion macros shared by the console writer RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: rtl/tcw_pkg.sv
// Package for the text console writer: geometry, codes, request and result types.
// Has no dependencies; used by text_console_writer_unit.
package tcw_pkg;

    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int CELLS  = COLS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CELL_W = 16;

    localparam logic [2:0] FN_PUT   = 3'd0;
    localparam logic [2:0] FN_ERASE = 3'd1;
    localparam logic [2:0] FN_CLEAR = 3'd2;
    localparam logic [2:0] FN_SETPOS = 3'd3;
    localparam logic [2:0] FN_READ  = 3'd4;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] ATTR_RESET = 8'd7;

    typedef struct packed {
        logic [2:0]       func;
        logic [7:0]       char_code;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } req_t;

    typedef struct packed {
        logic [10:0]       cursor_pos;
        logic [CELL_W-1:0] cell_data;
        logic              scrolled;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SCROLL,
        ST_BLANK
    } state_t;

endpackage

// File: rtl/text_console_writer_unit.sv
// Text console writer: character-cell store with a write cursor, top level.
// Depends on tcw_pkg and assert_macros.svh.
//
// Channel   Handshake             Payload
// request   start / busy          req  (tcw_pkg::req_t)
// result    done (one cycle)      rsp  (tcw_pkg::rsp_t)
// config    cfg_valid / cfg_ready cfg_data (attribute byte)
//
// Put, erase, set position and unused codes run in the exec state alone; read cell
// adds a read state, as the cell store has a registered read port.
// A clear runs a clearing pass, one cell written per cycle.
// A put that scrolls moves the rows up, one copy per cycle through the
// single read and write port, then one blank per cycle on the last row.
// After reset a clearing pass holds busy high.
// The result strobe cannot be stalled; a new request is taken as it shows.
`include "assert_macros.svh"

module text_console_writer_unit
    import tcw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        req,
    output logic        done,
    output rsp_t        rsp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_ROW_0 = ADDR_W'(CELLS - COLS);
    localparam logic [ADDR_W-1:0] ROW_STEP   = ADDR_W'(COLS);
    localparam logic [COL_W-1:0]  COL_MAX    = COL_W'(COLS - 1);
    localparam logic [ROW_W-1:0]  ROW_MAX    = ROW_W'(ROWS - 1);
    localparam logic [CELL_W-1:0] RESET_BLANK = {ATTR_RESET, CH_SPACE};

    state_t            state_reg, state_next;
    logic              init_reg, init_next;
    logic [7:0]        attr_reg;
    req_t              req_reg;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] waddr_reg, waddr_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] lin_reg, lin_next;
    logic              done_reg, done_next;
    rsp_t              rsp_reg, rsp_next;

    logic [CELL_W-1:0] mem [CELLS];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [CELL_W-1:0] mem_wdata, mem_rdata;

    logic              accept;
    logic              is_cr, is_lf, last_col, last_row, put_scroll;
    logic [COL_W-1:0]  cc;
    logic [ROW_W-1:0]  rc;
    logic [ADDR_W-1:0] pos_calc, erase_lin;
    logic [CELL_W-1:0] blank;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    assign is_cr      = (req_reg.char_code == CH_CR);
    assign is_lf      = (req_reg.char_code == CH_LF);
    assign last_col   = (col_reg == COL_MAX);
    assign last_row   = (row_reg == ROW_MAX);
    assign put_scroll = (req_reg.func == FN_PUT) && !is_cr && last_row && (is_lf || last_col);
    assign cc         = (req_reg.col > COL_MAX) ? COL_MAX : req_reg.col;
    assign rc         = (req_reg.row > ROW_MAX) ? ROW_MAX : req_reg.row;
    assign pos_calc   = ADDR_W'(rc) * ROW_STEP + ADDR_W'(cc);
    assign erase_lin  = (lin_reg == '0) ? '0 : lin_reg - ADDR_W'(1);
    assign blank      = init_reg ? RESET_BLANK : {attr_reg, CH_SPACE};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (req_reg.func)
                    FN_PUT:   state_next = put_scroll ? ST_SCROLL : ST_IDLE;
                    FN_CLEAR: state_next = ST_CLEAR;
                    FN_READ:  state_next = ST_READ;
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            ST_SCROLL:
            begin
                if (cnt_reg == LAST_ROW_0)
                begin
                    state_next = ST_BLANK;
                end
            end
            ST_BLANK:
            begin
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        init_next  = init_reg;
        cnt_next   = cnt_reg;
        pend_next  = 1'b0;
        waddr_next = waddr_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        lin_next   = lin_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        mem_we     = 1'b0;
        mem_waddr  = lin_reg;
        mem_wdata  = blank;
        mem_raddr  = pos_calc;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                cnt_next  = cnt_reg + ADDR_W'(1);
                if (cnt_reg == LAST_CELL)
                begin
                    init_next = 1'b0;
                    done_next = !init_reg;
                    rsp_next  = '{cursor_pos: 11'(lin_reg), cell_data: '0, scrolled: 1'b0};
                end
            end
            ST_EXEC:
            begin
                cnt_next = '0;
                case (req_reg.func)
                    FN_PUT:
                    begin
                        if (!is_cr)
                        begin
                            if (!is_lf)
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = {attr_reg, req_reg.char_code};
                            end
                            if (put_scroll)
                            begin
                                row_next = ROW_MAX;
                                col_next = '0;
                                lin_next = LAST_ROW_0;
                            end
                            else if (is_lf || last_col)
                            begin
                                row_next = row_reg + ROW_W'(1);
                                col_next = '0;
                                lin_next = lin_reg - ADDR_W'(col_reg) + ROW_STEP;
                            end
                            else
                            begin
                                col_next = col_reg + COL_W'(1);
                                lin_next = lin_reg + ADDR_W'(1);
                            end
                        end
                    end
                    FN_ERASE:
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = erase_lin;
                        lin_next  = erase_lin;
                        if (lin_reg != '0)
                        begin
                            if (col_reg == '0)
                            begin
                                col_next = COL_MAX;
                                row_next = row_reg - ROW_W'(1);
                            end
                            else
                            begin
                                col_next = col_reg - COL_W'(1);
                            end
                        end
                    end
                    FN_SETPOS:
                    begin
                        col_next = cc;
                        row_next = rc;
                        lin_next = pos_calc;
                    end
                    default:
                    begin
                    end
                endcase
                if (state_next == ST_IDLE)
                begin
                    done_next = 1'b1;
                    rsp_next  = '{cursor_pos: 11'(lin_next), cell_data: '0, scrolled: 1'b0};
                end
            end
            ST_READ:
            begin
                done_next = 1'b1;
                rsp_next  = '{cursor_pos: 11'(lin_reg), cell_data: mem_rdata, scrolled: 1'b0};
            end
            ST_SCROLL:
            begin
                mem_we    = pend_reg;
                mem_waddr = waddr_reg;
                mem_wdata = mem_rdata;
                mem_raddr = cnt_reg + ROW_STEP;
                if (cnt_reg != LAST_ROW_0)
                begin
                    pend_next  = 1'b1;
                    waddr_next = cnt_reg;
                    cnt_next   = cnt_reg + ADDR_W'(1);
                end
            end
            ST_BLANK:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                cnt_next  = cnt_reg + ADDR_W'(1);
                if (cnt_reg == LAST_CELL)
                begin
                    done_next = 1'b1;
                    rsp_next  = '{cursor_pos: 11'(lin_reg), cell_data: '0, scrolled: 1'b1};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            init_reg  <= 1'b1;
            attr_reg  <= ATTR_RESET;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            col_reg   <= '0;
            row_reg   <= '0;
            lin_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            lin_reg   <= lin_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                attr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        waddr_reg <= waddr_next;
        rsp_reg   <= rsp_next;
    end

    `ASSERT_CLK(a_accept_exec, accept |=> (state_reg == ST_EXEC), "request not executed")
    `ASSERT_CLK(a_cursor_bound, lin_reg <= LAST_CELL, "cursor beyond the store")
    `ASSERT_CLK(a_cursor_split, lin_reg == ADDR_W'(row_reg) * ROW_STEP + ADDR_W'(col_reg),
        "linear cursor disagrees with row and column")
    `ASSERT_NEVER(a_idle_no_write, (state_reg == ST_IDLE) && mem_we, "store written while idle")
    `ASSERT_CLK(a_done_after_work, done |-> ($past(state_reg) != ST_IDLE),
        "result without an operation")

endmodule

// File: tb/sv/text_console_writer_unit_tb.sv
// Self-checking testbench for text_console_writer_unit: directed and random requests,
// with a scoreboard class that predicts every result. Depends on tcw_pkg and the RTL.
`timescale 1ns / 1ps

module text_console_writer_unit_tb
    import tcw_pkg::*;
();

    localparam logic [2:0] FN_SPARE5 = 3'd5;
    localparam logic [2:0] FN_SPARE6 = 3'd6;
    localparam logic [2:0] FN_SPARE7 = 3'd7;
    localparam int IDLE_LIMIT = 12000;
    localparam int DRAIN_CYCLES = 50;

    class console_scoreboard;
        logic [CELL_W-1:0] cells [CELLS];
        int unsigned cursor;
        logic [7:0] attr;
        rsp_t expected_q[$];
        int mismatches;

        function new();
            attr = ATTR_RESET;
            cursor = 0;
            mismatches = 0;
            blank_all();
        endfunction

        function logic [CELL_W-1:0] blank_word();
            return {attr, CH_SPACE};
        endfunction

        function void blank_all();
            foreach (cells[i])
                cells[i] = blank_word();
        endfunction

        function int unsigned cell_index(logic [COL_W-1:0] c, logic [ROW_W-1:0] r);
            int unsigned cc;
            int unsigned rr;
            cc = (c >= COLS) ? COLS - 1 : c;
            rr = (r >= ROWS) ? ROWS - 1 : r;
            return rr * COLS + cc;
        endfunction

        function void set_attribute(logic [7:0] value);
            attr = value;
        endfunction

        function int unsigned cursor_row();
            return cursor / COLS;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Applies an accepted request to the model and queues the result it causes.
        function void note_request(req_t r);
            rsp_t exp_rsp;
            exp_rsp = '0;
            case (r.func)
                FN_PUT:
                begin
                    if (r.char_code != CH_CR) begin
                        if (r.char_code == CH_LF) begin
                            cursor = (cursor / COLS + 1) * COLS;
                        end else begin
                            cells[cursor] = {attr, r.char_code};
                            cursor++;
                        end
                        if (cursor >= CELLS) begin
                            for (int i = 0; i < CELLS - COLS; i++)
                                cells[i] = cells[i + COLS];
                            for (int i = CELLS - COLS; i < CELLS; i++)
                                cells[i] = blank_word();
                            cursor -= COLS;
                            exp_rsp.scrolled = 1'b1;
                        end
                    end
                end
                FN_ERASE:
                begin
                    if (cursor > 0)
                        cursor--;
                    cells[cursor] = blank_word();
                end
                FN_CLEAR:
                    blank_all();
                FN_SETPOS:
                    cursor = cell_index(r.col, r.row);
                FN_READ:
                    exp_rsp.cell_data = cells[cell_index(r.col, r.row)];
                default:
                    ;
            endcase
            exp_rsp.cursor_pos = cursor[10:0];
            expected_q.push_back(exp_rsp);
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(rsp_t got);
            rsp_t exp_rsp;
            if (expected_q.size() == 0) begin
                report("result strobe with no request outstanding");
            end else begin
                exp_rsp = expected_q.pop_front();
                if (got.cursor_pos !== exp_rsp.cursor_pos)
                    report($sformatf("cursor_pos got %0d expected %0d",
                                     got.cursor_pos, exp_rsp.cursor_pos));
                if (got.cell_data !== exp_rsp.cell_data)
                    report($sformatf("cell_data got %h expected %h",
                                     got.cell_data, exp_rsp.cell_data));
                if (got.scrolled !== exp_rsp.scrolled)
                    report($sformatf("scrolled got %b expected %b",
                                     got.scrolled, exp_rsp.scrolled));
            end
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    req_t       req = '0;
    logic       done;
    rsp_t       rsp;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = '0;

    console_scoreboard sb = new();
    int idle_cycles = 0;
    int burst_left = 0;

    text_console_writer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n) begin
            if (done)
                sb.check_result(rsp);
            if (start && !busy)
                sb.note_request(req);
            if (cfg_valid && cfg_ready)
                sb.set_attribute(cfg_data);
        end
    end

    always @(posedge clk) begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic req_t make_req(logic [2:0] f, logic [7:0] ch,
                                      logic [COL_W-1:0] c, logic [ROW_W-1:0] r);
        req_t item;
        item.func = f;
        item.char_code = ch;
        item.col = c;
        item.row = r;
        return item;
    endfunction

    function automatic logic [COL_W-1:0] pick_col();
        if ($urandom_range(0, 99) < 15)
            return COL_W'($urandom_range(0, 127));
        return COL_W'($urandom_range(0, COLS - 1));
    endfunction

    function automatic logic [ROW_W-1:0] pick_row();
        int k;
        k = $urandom_range(0, 99);
        if (k < 15)
            return ROW_W'($urandom_range(0, 31));
        if (k < 35)
            return ROW_W'(ROWS - 1);
        return ROW_W'($urandom_range(0, ROWS - 1));
    endfunction

    function automatic req_t random_req();
        req_t item;
        int k;
        int sub;
        item = make_req(FN_PUT, 8'($urandom_range(0, 255)), COL_W'($urandom_range(0, 127)),
                        ROW_W'($urandom_range(0, 31)));
        k = $urandom_range(0, 99);
        if (k < 50) begin
            sub = $urandom_range(0, 19);
            if (sub == 0)
                item.char_code = CH_CR;
            else if (sub <= 2)
                item.char_code = CH_LF;
            else if (sub > 4)
                item.char_code = 8'($urandom_range(32, 126));
        end else if (k < 58) begin
            item.func = FN_ERASE;
        end else if (k < 59) begin
            item.func = FN_CLEAR;
        end else if (k < 72) begin
            item.func = FN_SETPOS;
            item.col = pick_col();
            item.row = pick_row();
        end else if (k < 95) begin
            item.func = FN_READ;
            item.col = pick_col();
            if ($urandom_range(0, 1) == 0)
                item.row = ROW_W'(sb.cursor_row());
            else
                item.row = pick_row();
        end else begin
            item.func = 3'($urandom_range(FN_SPARE5, FN_SPARE7));
        end
        return item;
    endfunction

    // Presents one request and waits until it is taken; within a burst start stays high, and at
    // the end of a burst a new one is drawn and start may drop for a random gap.
    task automatic send_request(req_t item);
        int gap;
        start <= 1'b1;
        req <= item;
        do
            @(posedge clk);
        while (busy);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 11);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic write_attribute(logic [7:0] value);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        req_t directed_q[$];
        logic [7:0] attr_settings[$];

        directed_q = '{
            make_req(FN_READ, 8'h00, 7'd0, 5'd0),
            make_req(FN_PUT, 8'h41, 7'd0, 5'd0),
            make_req(FN_PUT, 8'h00, 7'd127, 5'd31),
            make_req(FN_PUT, 8'hFF, 7'd0, 5'd0),
            make_req(FN_PUT, CH_CR, 7'd0, 5'd0),
            make_req(FN_READ, 8'h00, 7'd2, 5'd0),
            make_req(FN_PUT, CH_LF, 7'd0, 5'd0),
            make_req(FN_SETPOS, 8'h00, 7'd0, 5'd0),
            make_req(FN_ERASE, 8'h00, 7'd0, 5'd0),
            make_req(FN_READ, 8'h00, 7'd0, 5'd0),
            make_req(FN_SETPOS, 8'h00, 7'd127, 5'd31),
            make_req(FN_PUT, 8'h5A, 7'd0, 5'd0),
            make_req(FN_READ, 8'hFF, 7'd127, 5'd31),
            make_req(FN_READ, 8'h00, COL_W'(COLS - 1), ROW_W'(ROWS - 2)),
            make_req(FN_SETPOS, 8'h00, 7'd5, ROW_W'(ROWS - 2)),
            make_req(FN_PUT, CH_LF, 7'd0, 5'd0),
            make_req(FN_PUT, CH_LF, 7'd0, 5'd0),
            make_req(FN_ERASE, 8'h00, 7'd0, 5'd0),
            make_req(FN_CLEAR, 8'h00, 7'd0, 5'd0),
            make_req(FN_READ, 8'h00, COL_W'(COLS - 1), ROW_W'(ROWS - 2)),
            make_req(FN_SPARE5, 8'hFF, 7'd127, 5'd31),
            make_req(FN_SPARE6, 8'h00, 7'd0, 5'd0),
            make_req(FN_SPARE7, 8'h00, 7'd0, 5'd0),
            make_req(FN_SETPOS, 8'h00, COL_W'(COLS - 1), ROW_W'(ROWS - 1)),
            make_req(FN_PUT, CH_CR, 7'd0, 5'd0)
        };
        attr_settings = '{8'h00, 8'hFF, 8'($urandom_range(1, 254))};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_q[i])
            send_request(directed_q[i]);

        foreach (attr_settings[p]) begin
            write_attribute(attr_settings[p]);
            repeat (p == 2 ? 350 : 300)
                send_request(random_req());
        end

        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
